[src/akf_pkg.sv]
// shared types, widths and saturation helpers for the altitude kalman filter
// used by akf_mul, akf_div and altitude_kalman_filter; no dependencies
package akf_pkg;

    // fixed-point layout
    localparam int Q_FRAC     = 16;   // q16.16 fraction bits
    localparam int WORD_W     = 32;   // state and measurement words
    localparam int DT_W       = 16;   // time step, q0.16
    localparam int COV_W      = 48;   // covariance entries, q24.24
    localparam int DEN_W      = COV_W + 1;
    localparam int NOISE_SH   = 8;    // q16.16 to q24.24
    localparam int PNQ_W      = 40;   // scaled process noise term
    localparam int ACC_W      = WORD_W + 2;
    localparam int SUM_W      = 66;   // wide adder for every saturating sum

    // shared multiplier: a (48 signed) times b (33 signed), floor shift by q_frac
    localparam int MUL_A_W    = COV_W;
    localparam int MUL_B_W    = WORD_W + 1;
    localparam int MUL_HI_W   = MUL_A_W - Q_FRAC;
    localparam int MUL_P_W    = 2 * MUL_B_W;
    localparam int MUL_R_W    = 64;

    localparam logic signed [COV_W-1:0]  COV_ONE     = COV_W'(64'd1 << 24);
    localparam logic [WORD_W-1:0]        NOISE_RESET = 32'h0001_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN    = 32'sh8000_0000;
    localparam logic signed [COV_W-1:0]  COV_MAX     = {1'b0, {(COV_W-1){1'b1}}};
    localparam logic signed [COV_W-1:0]  COV_MIN     = {1'b1, {(COV_W-1){1'b0}}};

    // action codes
    localparam logic [1:0] ACT_PROPAGATE   = 2'd0;
    localparam logic [1:0] ACT_UPD_DEFAULT = 2'd1;
    localparam logic [1:0] ACT_UPD_GIVEN   = 2'd2;
    localparam logic [1:0] ACT_UNUSED      = 2'd3;

    // register indexes
    localparam logic REG_PROCESS_NOISE = 1'b0;
    localparam logic REG_DEFAULT_NOISE = 1'b1;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [WORD_W-1:0] accel;
        logic [DT_W-1:0]          step_time;
        logic signed [WORD_W-1:0] measured_altitude;
        logic [WORD_W-1:0]        measurement_noise;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_W-1:0] altitude_estimate;
        logic signed [WORD_W-1:0] velocity_estimate;
        logic                     saturated;
    } t_out_word;

    typedef struct packed {
        logic                     hit;
        logic signed [WORD_W-1:0] val;
    } t_sat32;

    typedef struct packed {
        logic                    hit;
        logic signed [COV_W-1:0] val;
    } t_sat48;

    function automatic t_sat32 sat32(input logic signed [SUM_W-1:0] x);
        t_sat32 r;
        r.hit = !((&x[SUM_W-1:WORD_W-1]) || !(|x[SUM_W-1:WORD_W-1]));
        if (r.hit) begin
            r.val = x[SUM_W-1] ? WORD_MIN : WORD_MAX;
        end else begin
            r.val = x[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic t_sat48 sat48(input logic signed [SUM_W-1:0] x);
        t_sat48 r;
        r.hit = !((&x[SUM_W-1:COV_W-1]) || !(|x[SUM_W-1:COV_W-1]));
        if (r.hit) begin
            r.val = x[SUM_W-1] ? COV_MIN : COV_MAX;
        end else begin
            r.val = x[COV_W-1:0];
        end
        return r;
    endfunction

endpackage

[src/altitude_kalman_filter.sv]
// altitude / vertical velocity kalman filter, top level with sequencer and state
// depends on akf_pkg, akf_mul (shared multiplier) and akf_div (gain divider)
//
//  channel   direction  handshake              word
//  input     in         i_valid / o_stall      akf_pkg::t_in_word
//  result    out        o_valid / i_stall      akf_pkg::t_out_word
//  config    in         psel/penable/pready    process_noise @0, default_noise @4
//
// one word at a time; most steps wait on the shared multiplier or on the divider,
// which produces one quotient bit a cycle
// reset puts the estimates at zero and the covariance at identity
// a new word is taken while the last result still waits in the output register;
// a stalled result holds the sequencer at its final step
module altitude_kalman_filter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  akf_pkg::t_in_word     i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output akf_pkg::t_out_word    o_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_P_DTDT, ST_P_Q, ST_P_HV, ST_P_HA, ST_P_V,
        ST_P_U, ST_P_W, ST_P_P00, ST_P_T, ST_P_P01, ST_P_P11,
        ST_U_SY, ST_U_K0, ST_U_K1, ST_U_H, ST_U_V,
        ST_U_P10, ST_U_P11, ST_U_P00, ST_U_P01,
        ST_DONE
    } t_state;

    localparam int SUM_W = akf_pkg::SUM_W;

    t_state                                   r_state;
    logic                                     r_issued;
    logic                                     r_sat;
    logic                                     r_out_valid;
    akf_pkg::t_in_word                        r_in;
    akf_pkg::t_out_word                       r_out;
    logic [akf_pkg::WORD_W-1:0]               r_pn;
    logic [akf_pkg::WORD_W-1:0]               r_dn;
    logic signed [akf_pkg::WORD_W-1:0]        r_h;
    logic signed [akf_pkg::WORD_W-1:0]        r_v;
    logic signed [akf_pkg::COV_W-1:0]         r_p00;
    logic signed [akf_pkg::COV_W-1:0]         r_p01;
    logic signed [akf_pkg::COV_W-1:0]         r_p10;
    logic signed [akf_pkg::COV_W-1:0]         r_p11;
    logic [akf_pkg::DT_W-1:0]                 r_dtdt;
    logic [akf_pkg::PNQ_W-1:0]                r_q;
    logic signed [akf_pkg::ACC_W-1:0]         r_acc;
    logic signed [akf_pkg::COV_W-1:0]         r_tmp;
    logic signed [akf_pkg::DEN_W-1:0]         r_s;
    logic signed [akf_pkg::WORD_W-1:0]        r_y;
    logic signed [akf_pkg::WORD_W-1:0]        r_k0;
    logic signed [akf_pkg::WORD_W-1:0]        r_k1;

    logic                                     in_accept;
    logic                                     is_mul;
    logic                                     is_div;
    logic                                     mul_start;
    logic                                     mul_done;
    logic signed [akf_pkg::MUL_A_W-1:0]       mul_a;
    logic signed [akf_pkg::MUL_B_W-1:0]       mul_b;
    logic signed [akf_pkg::MUL_R_W-1:0]       mul_res;
    logic                                     div_start;
    logic                                     div_done;
    logic signed [akf_pkg::COV_W-1:0]         div_num;
    logic signed [akf_pkg::WORD_W-1:0]        div_quot;
    logic                                     div_sat;
    logic [akf_pkg::WORD_W-1:0]               noise;
    logic signed [akf_pkg::DEN_W-1:0]         n_s;
    logic signed [SUM_W-1:0]                  m_ext;
    logic signed [SUM_W-1:0]                  q_full;
    logic signed [SUM_W-1:0]                  x_sum;
    logic signed [SUM_W-1:0]                  x_alt;
    akf_pkg::t_sat32                          s32;
    akf_pkg::t_sat48                          s48;
    akf_pkg::t_sat48                          s48b;

    assign in_accept = i_valid && !o_stall;
    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == akf_pkg::REG_DEFAULT_NOISE) ? r_dn : r_pn;

    assign mul_start = is_mul && !r_issued;
    assign div_start = is_div && !r_issued;

    assign noise  = (r_in.action == akf_pkg::ACT_UPD_GIVEN) ? r_in.measurement_noise : r_dn;
    assign n_s    = akf_pkg::DEN_W'(r_p00)
                  + $signed(akf_pkg::DEN_W'({noise, akf_pkg::NOISE_SH'(0)}));
    assign m_ext  = SUM_W'(mul_res);
    assign q_full = $signed(SUM_W'(r_q));

    // operand selection and the wide adders of each step
    always_comb begin
        is_mul  = 1'b0;
        is_div  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        div_num = r_p00;
        x_sum   = '0;
        x_alt   = '0;
        case (r_state)
            ST_P_DTDT: begin
                is_mul = 1'b1;
                mul_a  = $signed(akf_pkg::MUL_A_W'(r_in.step_time));
                mul_b  = $signed(akf_pkg::MUL_B_W'(r_in.step_time));
            end
            ST_P_Q: begin
                // (noise * dtdt) >> 8 as a q16 product of noise << 8
                is_mul = 1'b1;
                mul_a  = $signed(akf_pkg::MUL_A_W'({r_pn, akf_pkg::NOISE_SH'(0)}));
                mul_b  = $signed(akf_pkg::MUL_B_W'(r_dtdt));
            end
            ST_P_HV: begin
                is_mul = 1'b1;
                mul_a  = akf_pkg::MUL_A_W'(r_v);
                mul_b  = $signed(akf_pkg::MUL_B_W'(r_in.step_time));
            end
            ST_P_HA: begin
                is_mul = 1'b1;
                mul_a  = akf_pkg::MUL_A_W'(r_in.accel);
                mul_b  = $signed(akf_pkg::MUL_B_W'(r_dtdt));
                x_sum  = SUM_W'(r_acc) + (m_ext >>> 1);
            end
            ST_P_V: begin
                is_mul = 1'b1;
                mul_a  = akf_pkg::MUL_A_W'(r_in.accel);
                mul_b  = $signed(akf_pkg::MUL_B_W'(r_in.step_time));
                x_sum  = SUM_W'(r_v) + m_ext;
            end
            ST_P_U: begin
                x_sum = SUM_W'(r_p11) + (q_full >>> 2);
            end
            ST_P_W: begin
                is_mul = 1'b1;
                mul_a  = r_tmp;
                mul_b  = $signed(akf_pkg::MUL_B_W'(r_in.step_time));
                x_sum  = SUM_W'(r_p10) + SUM_W'(r_p01) + m_ext;
            end
            ST_P_P00: begin
                is_mul = 1'b1;
                mul_a  = r_tmp;
                mul_b  = $signed(akf_pkg::MUL_B_W'(r_in.step_time));
                x_sum  = SUM_W'(r_p00) + m_ext;
            end
            ST_P_T: begin
                x_sum = SUM_W'(r_p11) + (q_full >>> 1);
            end
            ST_P_P01: begin
                is_mul = 1'b1;
                mul_a  = r_tmp;
                mul_b  = $signed(akf_pkg::MUL_B_W'(r_in.step_time));
                x_sum  = SUM_W'(r_p01) + m_ext;
                x_alt  = SUM_W'(r_p10) + m_ext;
            end
            ST_P_P11: begin
                x_sum = SUM_W'(r_p11) + q_full;
            end
            ST_U_SY: begin
                x_sum = SUM_W'(r_in.measured_altitude) - SUM_W'(r_h);
            end
            ST_U_K0: begin
                is_div  = 1'b1;
                div_num = r_p00;
            end
            ST_U_K1: begin
                is_div  = 1'b1;
                div_num = r_p10;
            end
            ST_U_H: begin
                is_mul = 1'b1;
                mul_a  = akf_pkg::MUL_A_W'(r_y);
                mul_b  = akf_pkg::MUL_B_W'(r_k0);
                x_sum  = SUM_W'(r_h) + m_ext;
            end
            ST_U_V: begin
                is_mul = 1'b1;
                mul_a  = akf_pkg::MUL_A_W'(r_y);
                mul_b  = akf_pkg::MUL_B_W'(r_k1);
                x_sum  = SUM_W'(r_v) + m_ext;
            end
            // covariance correction runs on pre-update p00 and p01
            ST_U_P10: begin
                is_mul = 1'b1;
                mul_a  = r_p00;
                mul_b  = akf_pkg::MUL_B_W'(r_k1);
                x_sum  = SUM_W'(r_p10) - m_ext;
            end
            ST_U_P11: begin
                is_mul = 1'b1;
                mul_a  = r_p01;
                mul_b  = akf_pkg::MUL_B_W'(r_k1);
                x_sum  = SUM_W'(r_p11) - m_ext;
            end
            ST_U_P00: begin
                is_mul = 1'b1;
                mul_a  = r_p00;
                mul_b  = akf_pkg::MUL_B_W'(r_k0);
                x_sum  = SUM_W'(r_p00) - m_ext;
            end
            ST_U_P01: begin
                is_mul = 1'b1;
                mul_a  = r_p01;
                mul_b  = akf_pkg::MUL_B_W'(r_k0);
                x_sum  = SUM_W'(r_p01) - m_ext;
            end
            default: begin
                is_mul = 1'b0;
            end
        endcase
    end

    assign s32  = akf_pkg::sat32(x_sum);
    assign s48  = akf_pkg::sat48(x_sum);
    assign s48b = akf_pkg::sat48(x_alt);

    akf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    akf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_s),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_sat   (div_sat)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pn <= akf_pkg::NOISE_RESET;
            r_dn <= akf_pkg::NOISE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == akf_pkg::REG_PROCESS_NOISE) begin
                r_pn <= pwdata;
            end else begin
                r_dn <= pwdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            r_h         <= '0;
            r_v         <= '0;
            r_p00       <= akf_pkg::COV_ONE;
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= akf_pkg::COV_ONE;
        end else begin
            if (mul_start || div_start) begin
                r_issued <= 1'b1;
            end else if (mul_done || div_done) begin
                r_issued <= 1'b0;
            end
            // the final step reloads the output register itself
            if (r_out_valid && !i_stall && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_in  <= i_data;
                        r_sat <= 1'b0;
                        case (i_data.action)
                            akf_pkg::ACT_PROPAGATE:   r_state <= ST_P_DTDT;
                            akf_pkg::ACT_UPD_DEFAULT: r_state <= ST_U_SY;
                            akf_pkg::ACT_UPD_GIVEN:   r_state <= ST_U_SY;
                            default:                  r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_P_DTDT: begin
                    if (mul_done) begin
                        r_dtdt  <= mul_res[akf_pkg::DT_W-1:0];
                        r_state <= ST_P_Q;
                    end
                end
                ST_P_Q: begin
                    if (mul_done) begin
                        r_q     <= mul_res[akf_pkg::PNQ_W-1:0];
                        r_state <= ST_P_HV;
                    end
                end
                ST_P_HV: begin
                    if (mul_done) begin
                        r_acc   <= akf_pkg::ACC_W'(r_h) + akf_pkg::ACC_W'(mul_res);
                        r_state <= ST_P_HA;
                    end
                end
                ST_P_HA: begin
                    if (mul_done) begin
                        r_h     <= s32.val;
                        r_sat   <= r_sat | s32.hit;
                        r_state <= ST_P_V;
                    end
                end
                ST_P_V: begin
                    if (mul_done) begin
                        r_v     <= s32.val;
                        r_sat   <= r_sat | s32.hit;
                        r_state <= ST_P_U;
                    end
                end
                ST_P_U: begin
                    r_tmp   <= s48.val;
                    r_sat   <= r_sat | s48.hit;
                    r_state <= ST_P_W;
                end
                ST_P_W: begin
                    if (mul_done) begin
                        r_tmp   <= s48.val;
                        r_sat   <= r_sat | s48.hit;
                        r_state <= ST_P_P00;
                    end
                end
                ST_P_P00: begin
                    if (mul_done) begin
                        r_p00   <= s48.val;
                        r_sat   <= r_sat | s48.hit;
                        r_state <= ST_P_T;
                    end
                end
                ST_P_T: begin
                    r_tmp   <= s48.val;
                    r_sat   <= r_sat | s48.hit;
                    r_state <= ST_P_P01;
                end
                ST_P_P01: begin
                    if (mul_done) begin
                        r_p01   <= s48.val;
                        r_p10   <= s48b.val;
                        r_sat   <= r_sat | s48.hit | s48b.hit;
                        r_state <= ST_P_P11;
                    end
                end
                ST_P_P11: begin
                    r_p11   <= s48.val;
                    r_sat   <= r_sat | s48.hit;
                    r_state <= ST_DONE;
                end
                ST_U_SY: begin
                    r_s     <= n_s;
                    r_y     <= s32.val;
                    r_sat   <= r_sat | s32.hit;
                    r_state <= ST_U_K0;
                end
                ST_U_K0: begin
                    if (div_done) begin
                        r_k0    <= div_quot;
                        r_sat   <= r_sat | div_sat;
                        r_state <= ST_U_K1;
                    end
                end
                ST_U_K1: begin
                    if (div_done) begin
                        r_k1    <= div_quot;
                        r_sat   <= r_sat | div_sat;
                        r_state <= ST_U_H;
                    end
                end
                ST_U_H: begin
                    if (mul_done) begin
                        r_h     <= s32.val;
                        r_sat   <= r_sat | s32.hit;
                        r_state <= ST_U_V;
                    end
                end
                ST_U_V: begin
                    if (mul_done) begin
                        r_v     <= s32.val;
                        r_sat   <= r_sat | s32.hit;
                        r_state <= ST_U_P10;
                    end
                end
                ST_U_P10: begin
                    if (mul_done) begin
                        r_p10   <= s48.val;
                        r_sat   <= r_sat | s48.hit;
                        r_state <= ST_U_P11;
                    end
                end
                ST_U_P11: begin
                    if (mul_done) begin
                        r_p11   <= s48.val;
                        r_sat   <= r_sat | s48.hit;
                        r_state <= ST_U_P00;
                    end
                end
                ST_U_P00: begin
                    if (mul_done) begin
                        r_p00   <= s48.val;
                        r_sat   <= r_sat | s48.hit;
                        r_state <= ST_U_P01;
                    end
                end
                ST_U_P01: begin
                    if (mul_done) begin
                        r_p01   <= s48.val;
                        r_sat   <= r_sat | s48.hit;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // output register free or being emptied this cycle
                    if (!r_out_valid || !i_stall) begin
                        r_out.altitude_estimate <= r_h;
                        r_out.velocity_estimate <= r_v;
                        r_out.saturated         <= r_sat;
                        r_out_valid             <= 1'b1;
                        r_state                 <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

[src/akf_mul.sv]
// shared multiplier: floor(a * b / 2^16) with a 48-bit signed and b 33-bit signed
// one 33x33 multiplier used twice (low then high half of a); uses akf_pkg
module akf_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [akf_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [akf_pkg::MUL_B_W-1:0]   i_b,
    output logic                                 o_done,
    output logic signed [akf_pkg::MUL_R_W-1:0]   o_res
);

    typedef enum logic [1:0] {S_IDLE, S_LO, S_HI, S_SUM} t_state;

    t_state                                   r_state;
    logic signed [akf_pkg::MUL_HI_W-1:0]      r_hi;
    logic [akf_pkg::Q_FRAC-1:0]               r_lo;
    logic signed [akf_pkg::MUL_B_W-1:0]       r_b;
    logic signed [akf_pkg::MUL_P_W-1:0]       r_prod;
    logic signed [akf_pkg::MUL_R_W-1:0]       r_acc;

    logic signed [akf_pkg::MUL_B_W-1:0]       opa;
    logic signed [akf_pkg::MUL_P_W-1:0]       prod;

    // low half goes in unsigned, high half carries the sign
    assign opa  = (r_state == S_LO) ? $signed(akf_pkg::MUL_B_W'(r_lo))
                                    : akf_pkg::MUL_B_W'(r_hi);
    assign prod = opa * r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_hi    <= i_a[akf_pkg::MUL_A_W-1:akf_pkg::Q_FRAC];
                        r_lo    <= i_a[akf_pkg::Q_FRAC-1:0];
                        r_b     <= i_b;
                        r_state <= S_LO;
                    end
                end
                S_LO: begin
                    r_prod  <= prod;
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_acc   <= akf_pkg::MUL_R_W'(r_prod >>> akf_pkg::Q_FRAC);
                    r_prod  <= prod;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    o_res   <= r_acc + $signed(r_prod[akf_pkg::MUL_R_W-1:0]);
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[src/akf_div.sv]
// gain divider: signed q16.16 quotient of two q24.24 values, saturating
// restoring division, one quotient bit a cycle; uses akf_pkg
module akf_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [akf_pkg::COV_W-1:0]     i_num,
    input  logic signed [akf_pkg::DEN_W-1:0]     i_den,
    output logic                                 o_done,
    output logic signed [akf_pkg::WORD_W-1:0]    o_quot,
    output logic                                 o_sat
);

    typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN, D_FIN} t_state;

    localparam int CNT_W = $clog2(akf_pkg::WORD_W);

    t_state                          r_state;
    logic                            r_neg;
    logic                            r_zero;
    logic                            r_ovf;
    logic [akf_pkg::COV_W-1:0]       r_mn;
    logic [akf_pkg::DEN_W-1:0]       r_md;
    logic [akf_pkg::DEN_W-1:0]       r_rem;
    logic [akf_pkg::WORD_W-1:0]      r_low;
    logic [CNT_W-1:0]                r_cnt;

    logic [akf_pkg::DEN_W:0]         trial;
    logic                            ge;
    logic [akf_pkg::DEN_W:0]         diff;

    assign trial = {r_rem, r_low[akf_pkg::WORD_W-1]};
    assign ge    = trial >= {1'b0, r_md};
    assign diff  = trial - {1'b0, r_md};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        // zero divisor takes its sign from the numerator alone
                        r_neg  <= (i_den == '0) ? i_num[akf_pkg::COV_W-1]
                                 : (i_num[akf_pkg::COV_W-1] ^ i_den[akf_pkg::DEN_W-1]);
                        r_zero <= (i_den == '0);
                        r_mn   <= i_num[akf_pkg::COV_W-1] ? -i_num : i_num;
                        r_md   <= i_den[akf_pkg::DEN_W-1] ? -i_den : i_den;
                        r_state <= D_CHECK;
                    end
                end
                D_CHECK: begin
                    // quotient of 2^32 or more cannot fit either sign
                    if (r_zero || ({17'b0, r_mn} >= {r_md, 16'b0})) begin
                        r_ovf   <= 1'b1;
                        r_state <= D_FIN;
                    end else begin
                        r_ovf   <= 1'b0;
                        r_rem   <= akf_pkg::DEN_W'(r_mn[akf_pkg::COV_W-1:akf_pkg::Q_FRAC]);
                        r_low   <= {r_mn[akf_pkg::Q_FRAC-1:0], 16'b0};
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= ge ? diff[akf_pkg::DEN_W-1:0] : trial[akf_pkg::DEN_W-1:0];
                    r_low <= {r_low[akf_pkg::WORD_W-2:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(akf_pkg::WORD_W - 1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    o_done  <= 1'b1;
                    r_state <= D_IDLE;
                    if (r_ovf) begin
                        o_quot <= r_neg ? akf_pkg::WORD_MIN : akf_pkg::WORD_MAX;
                        o_sat  <= 1'b1;
                    end else if (r_neg) begin
                        if (r_low > 32'h8000_0000) begin
                            o_quot <= akf_pkg::WORD_MIN;
                            o_sat  <= 1'b1;
                        end else begin
                            o_quot <= -$signed(r_low);
                            o_sat  <= 1'b0;
                        end
                    end else if (r_low[akf_pkg::WORD_W-1]) begin
                        o_quot <= akf_pkg::WORD_MAX;
                        o_sat  <= 1'b1;
                    end else begin
                        o_quot <= $signed(r_low);
                        o_sat  <= 1'b0;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

endmodule
